>>> hw/rtl/lurt_pkg.sv
// ----------------------------------------------------------------------------
// lurt_pkg
// Shared types and field widths for the longest uniform run tracker:
// transaction payloads of the command and result channels.
// ----------------------------------------------------------------------------
package lurt_pkg;

    // fixed field widths of the channels
    localparam int unsigned MODE_W  = 1;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned LRUN_W  = 11;
    localparam int unsigned SLEN_W  = 11;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 1'b0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 1'b1;

    // command transaction
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] character;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [LRUN_W-1:0] longest_run;
        logic              bad_position;
    } t_out_item;

endpackage

>>> hw/rtl/longest_uniform_run_tracker_core.sv
// ----------------------------------------------------------------------------
// longest_uniform_run_tracker_core
// Keeps a character string in a segment tree and reports the longest run of
// one repeated character after each update write.
// ----------------------------------------------------------------------------
// an in-range write runs S_W_ISSUE, then S_W_WALK leaf to root, one tree level
//   a cycle through the shared merge unit; update strobes come with busy low again
// commands are taken only when idle; bad updates are busy in S_ROOT_RD, S_ROOT_OUT
// reset and each length write rebuild all 2*leaves-1 nodes through S_SW_RD and
//   S_SW_WR, busy meanwhile; reset also clears every character to zero
// results are strobed for one cycle and cannot be stalled
module longest_uniform_run_tracker_core #(
    parameter int unsigned MAX_LENGTH = 1024,
    parameter int unsigned CHAR_BITS  = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  lurt_pkg::t_in_item       i_item,
    output logic                     o_result_valid,
    output lurt_pkg::t_out_item      o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [lurt_pkg::SLEN_W-1:0] i_cfg_wdata
);

    import lurt_pkg::*;

    localparam int unsigned PW      = $clog2(MAX_LENGTH);
    localparam int unsigned NL      = 1 << PW;
    localparam int unsigned AW      = PW + 1;
    localparam int unsigned DEPTH   = 2 * NL;
    localparam int unsigned RW      = $clog2(MAX_LENGTH + 1);
    localparam int unsigned CW      = CHAR_BITS;
    localparam int unsigned NW      = 4 * RW + 2 * CW;
    localparam int unsigned RST_EFF = (MAX_LENGTH < 1024) ? MAX_LENGTH : 1024;

    typedef struct packed {
        logic [RW-1:0] len;
        logic [RW-1:0] pre;
        logic [RW-1:0] suf;
        logic [RW-1:0] best;
        logic [CW-1:0] lc;
        logic [CW-1:0] rc;
    } t_node;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SW_RD,
        S_SW_WR,
        S_W_ISSUE,
        S_W_WALK,
        S_ROOT_RD,
        S_ROOT_OUT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_k;
    logic          r_clear;
    logic [RW-1:0] r_eff;
    logic [RW-1:0] n_eff;
    logic          r_mode;
    t_node         r_cur;
    logic          r_result_valid;
    t_out_item     r_result;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_node         wr_data;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    t_node         rd_a_q;
    t_node         rd_b_q;
    t_node         mrg_a;
    t_node         mrg_b;
    t_node         mrg_y;
    t_node         sw_leaf;
    t_node         in_leaf;
    logic          sw_used;
    logic          in_bad;
    logic [AW-1:0] leaf_idx;

    // node store
    lurt_node_ram #(
        .DEPTH(DEPTH),
        .WIDTH(NW)
    ) u_ram (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_a_addr(rd_a_addr),
        .i_rd_b_addr(rd_b_addr),
        .o_rd_a_data(rd_a_q),
        .o_rd_b_data(rd_b_q)
    );

    // shared merge unit
    lurt_merge #(
        .RW(RW),
        .CW(CW)
    ) u_merge (
        .i_left (mrg_a),
        .i_right(mrg_b),
        .o_node (mrg_y)
    );

    // effective length of a configuration transaction
    assign n_eff = (32'(i_cfg_wdata) > MAX_LENGTH) ? RW'(MAX_LENGTH) : RW'(i_cfg_wdata);

    // incoming write: range check and fresh leaf
    assign in_bad   = (32'(i_item.position) >= 32'(r_eff));
    assign leaf_idx = {1'b1, PW'(i_item.position)};
    always_comb begin
        in_leaf      = '0;
        in_leaf.len  = RW'(1);
        in_leaf.pre  = RW'(1);
        in_leaf.suf  = RW'(1);
        in_leaf.best = RW'(1);
        in_leaf.lc   = CW'(i_item.character);
        in_leaf.rc   = CW'(i_item.character);
    end

    // rebuild sweep leaf: keeps its character unless clearing after reset
    assign sw_used = (RW'(r_k[PW-1:0]) < r_eff);
    always_comb begin
        sw_leaf      = '0;
        sw_leaf.len  = RW'(sw_used);
        sw_leaf.pre  = RW'(sw_used);
        sw_leaf.suf  = RW'(sw_used);
        sw_leaf.best = RW'(sw_used);
        sw_leaf.lc   = r_clear ? '0 : rd_a_q.lc;
        sw_leaf.rc   = r_clear ? '0 : rd_a_q.lc;
    end

    // store addressing and merge operand selection
    always_comb begin
        rd_a_addr = '0;
        rd_b_addr = '0;
        wr_en     = 1'b0;
        wr_addr   = r_k;
        wr_data   = r_cur;
        mrg_a     = r_cur;
        mrg_b     = rd_a_q;
        unique case (r_state)
            S_SW_RD: begin
                rd_a_addr = r_k[AW-1] ? r_k : {r_k[AW-2:0], 1'b0};
                rd_b_addr = {r_k[AW-2:0], 1'b1};
            end
            S_SW_WR: begin
                wr_en   = 1'b1;
                mrg_a   = rd_a_q;
                mrg_b   = rd_b_q;
                wr_data = r_k[AW-1] ? sw_leaf : mrg_y;
            end
            S_W_ISSUE: begin
                rd_a_addr = r_k ^ AW'(1);
            end
            S_W_WALK: begin
                wr_en     = 1'b1;
                rd_a_addr = (r_k >> 1) ^ AW'(1);
                if (r_k[0]) begin
                    mrg_a = rd_a_q;
                    mrg_b = r_cur;
                end
            end
            S_ROOT_RD: begin
                rd_a_addr = AW'(1);
            end
            default: begin
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_SW_RD;
            r_k            <= '1;
            r_clear        <= 1'b1;
            r_eff          <= RW'(RST_EFF);
            r_mode         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= ((r_state == S_W_WALK) && (r_k == AW'(1)) && r_mode) ||
                              (r_state == S_ROOT_OUT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_eff   <= n_eff;
                r_k     <= '1;
                r_state <= S_SW_RD;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_start) begin
                            r_mode <= (i_item.mode == MODE_UPDATE);
                            if (!in_bad) begin
                                r_k     <= leaf_idx;
                                r_cur   <= in_leaf;
                                r_state <= S_W_ISSUE;
                            end else if (i_item.mode == MODE_UPDATE) begin
                                r_state <= S_ROOT_RD;
                            end
                        end
                    end
                    S_SW_RD: begin
                        r_state <= S_SW_WR;
                    end
                    S_SW_WR: begin
                        if (r_k == AW'(1)) begin
                            r_clear <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k - AW'(1);
                            r_state <= S_SW_RD;
                        end
                    end
                    S_W_ISSUE: begin
                        r_state <= S_W_WALK;
                    end
                    S_W_WALK: begin
                        if (r_k == AW'(1)) begin
                            r_result.longest_run  <= LRUN_W'(r_cur.best);
                            r_result.bad_position <= 1'b0;
                            r_state               <= S_IDLE;
                        end else begin
                            r_cur <= mrg_y;
                            r_k   <= r_k >> 1;
                        end
                    end
                    S_ROOT_RD: begin
                        r_state <= S_ROOT_OUT;
                    end
                    S_ROOT_OUT: begin
                        r_result.longest_run  <= LRUN_W'(rd_a_q.best);
                        r_result.bad_position <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // length writes only while idle and no command transaction is offered
    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;
    assign o_cfg_ready    = (r_state == S_IDLE) && !i_start;

endmodule

>>> hw/rtl/lurt_node_ram.sv
// ----------------------------------------------------------------------------
// lurt_node_ram
// Segment tree node store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lurt_node_ram #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned WIDTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_a_addr,
    input  logic [$clog2(DEPTH)-1:0] i_rd_b_addr,
    output logic [WIDTH-1:0]         o_rd_a_data,
    output logic [WIDTH-1:0]         o_rd_b_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_a_addr];
        r_rd_b <= r_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

>>> hw/rtl/lurt_merge.sv
// ----------------------------------------------------------------------------
// lurt_merge
// Shared node merge unit: joins a left and a right segment, extending the
// prefix, suffix and best runs across the boundary when the characters match.
// ----------------------------------------------------------------------------
module lurt_merge #(
    parameter int unsigned RW = 11,
    parameter int unsigned CW = 8
) (
    input  logic [4*RW+2*CW-1:0] i_left,
    input  logic [4*RW+2*CW-1:0] i_right,
    output logic [4*RW+2*CW-1:0] o_node
);

    typedef struct packed {
        logic [RW-1:0] len;
        logic [RW-1:0] pre;
        logic [RW-1:0] suf;
        logic [RW-1:0] best;
        logic [CW-1:0] lc;
        logic [CW-1:0] rc;
    } t_node;

    function automatic logic [RW-1:0] umax(input logic [RW-1:0] a, input logic [RW-1:0] b);
        umax = (a > b) ? a : b;
    endfunction

    t_node         a;
    t_node         b;
    t_node         y;
    logic          eq;
    logic [RW-1:0] cross_run;
    logic [RW-1:0] pre;
    logic [RW-1:0] suf;

    assign a = i_left;
    assign b = i_right;

    // boundary join
    assign eq        = (a.rc == b.lc);
    assign cross_run = eq ? (a.suf + b.pre) : '0;
    assign pre       = (eq && (a.pre == a.len)) ? (a.len + b.pre) : a.pre;
    assign suf       = (eq && (b.suf == b.len)) ? (b.len + a.suf) : b.suf;

    // empty segments pass the other side through unchanged
    always_comb begin
        y = a;
        if (a.len == '0) begin
            y = b;
        end else if (b.len != '0) begin
            y.len  = a.len + b.len;
            y.lc   = a.lc;
            y.rc   = b.rc;
            y.pre  = pre;
            y.suf  = suf;
            y.best = umax(umax(a.best, b.best), umax(cross_run, umax(pre, suf)));
        end
    end

    assign o_node = y;

endmodule

>>> hw/rtl/lurt_checker.sv
// ----------------------------------------------------------------------------
// lurt_checker
// Port-level checks of the run tracker's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module lurt_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                o_busy,
    input  lurt_pkg::t_in_item  i_item,
    input  logic                o_result_valid,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready
);

    import lurt_pkg::*;

    // reset starts the clearing sweep
    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("no clearing sweep after reset");

    // an update transaction always keeps the block busy for a while
    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.mode == MODE_UPDATE) |=> o_busy)
        else $error("update transaction did not occupy the block");

    // a result ends a busy stretch
    a_result_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!o_busy && $past(o_busy)))
        else $error("result strobe outside the end of a busy stretch");

    // result strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe repeated");

    // a length write triggers the rebuild sweep
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_busy)
        else $error("no rebuild after length write");

endmodule

bind longest_uniform_run_tracker_core lurt_checker u_lurt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_item        (i_item),
    .o_result_valid(o_result_valid),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

>>> test/longest_uniform_run_tracker_core_test.sv
// ----------------------------------------------------------------------------
// longest_uniform_run_tracker_core_test
// Self-checking bench for the run tracker core: keeps a flat copy of the
// string and the length register, predicts each update result by scanning
// for the longest run of one character, and checks every strobed result.
// ----------------------------------------------------------------------------
module longest_uniform_run_tracker_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lurt_pkg::*;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned MAX_LEN      = 1024;
    localparam int unsigned SETTLE_TICKS = 24;
    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned GAP_PCT      = 23;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_start     = 1'b0;
    logic              o_busy;
    t_in_item          i_item      = '0;
    logic              o_result_valid;
    t_out_item         o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SLEN_W-1:0] i_cfg_wdata = '0;

    // shadow of the string and the length register
    logic [CHAR_W-1:0] char_store [MAX_LEN];
    logic [SLEN_W-1:0] length_reg;
    t_out_item         expected_runs [$];
    int unsigned       error_count  = 0;
    int unsigned       stall_cycles = 0;
    bit                gaps_on      = 1'b1;

    longest_uniform_run_tracker_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // positions in use: a length above the maximum counts as the maximum
    function automatic int unsigned active_len();
        return (length_reg > MAX_LEN) ? MAX_LEN : int'(length_reg);
    endfunction

    // apply one accepted write to the shadow string, queue the run it reports
    function automatic void predict_write(input t_in_item cmd);
        int unsigned n;
        int unsigned run;
        int unsigned best;
        logic        bad;
        t_out_item   res;
        n    = active_len();
        bad  = (cmd.position >= n);
        run  = 0;
        best = 0;
        if (!bad) begin
            char_store[cmd.position] = cmd.character;
        end
        if (cmd.mode == MODE_UPDATE) begin
            for (int unsigned p = 0; p < n; p++) begin
                if (p > 0 && char_store[POS_W'(p)] == char_store[POS_W'(p - 1)]) begin
                    run++;
                end else begin
                    run = 1;
                end
                if (run > best) begin
                    best = run;
                end
            end
            res.longest_run  = best[LRUN_W-1:0];
            res.bad_position = bad;
            expected_runs    = {expected_runs, res};
        end
    endfunction

    // random write: small alphabets build runs, zero alphabet means any code
    function automatic t_in_item random_cmd(input int unsigned alphabet,
                                            input int unsigned wild_pct);
        t_in_item    cmd;
        int unsigned n;
        n = active_len();
        cmd.mode = ($urandom_range(99) < 60) ? MODE_UPDATE : MODE_LOAD;
        if (n == 0 || $urandom_range(99) < wild_pct) begin
            cmd.position = POS_W'($urandom_range(MAX_LEN - 1));
        end else begin
            cmd.position = POS_W'($urandom_range(n - 1));
        end
        if (alphabet == 0) begin
            cmd.character = CHAR_W'($urandom);
        end else begin
            cmd.character = CHAR_W'($urandom_range(alphabet - 1));
        end
        return cmd;
    endfunction

    // one command transaction; start stays high so the next one can follow
    task automatic send_item(input t_in_item cmd);
        if (gaps_on) begin
            while ($urandom_range(99) < GAP_PCT) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_item  <= cmd;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_write(cmd);
    endtask

    task automatic send_write(input logic [MODE_W-1:0] mode,
                              input logic [POS_W-1:0]  pos,
                              input logic [CHAR_W-1:0] ch);
        t_in_item cmd;
        cmd.mode      = mode;
        cmd.position  = pos;
        cmd.character = ch;
        send_item(cmd);
    endtask

    // stop sending, let every result arrive, then let a load finish its walk
    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // length register write on the config channel, only while idle
    task automatic write_length(input logic [SLEN_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_wdata <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        length_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int unsigned count, input int unsigned alphabet,
                               input int unsigned wild_pct);
        repeat (count) send_item(random_cmd(alphabet, wild_pct));
    endtask

    // reset string of zeros, field extremes at full length
    task automatic test_reset_string();
        send_write(MODE_UPDATE, 10'd0,   8'h00);
        send_write(MODE_UPDATE, 10'd1023, 8'hFF);
        send_write(MODE_UPDATE, 10'd0,   8'hFF);
        send_write(MODE_LOAD,   10'd512, 8'hAA);
        send_write(MODE_UPDATE, 10'd511, 8'h55);
        send_write(MODE_UPDATE, 10'd1023, 8'h00);
        send_write(MODE_UPDATE, 10'd0,   8'h00);
    endtask

    // zero length, length above the maximum, single position, regrowth
    task automatic test_length_extremes();
        write_length(11'd0);
        send_write(MODE_UPDATE, 10'd0,   8'h01);
        send_write(MODE_LOAD,   10'd0,   8'h01);
        send_write(MODE_UPDATE, 10'd1023, 8'h7F);
        write_length(11'h7FF);
        send_write(MODE_UPDATE, 10'd1023, 8'h80);
        send_write(MODE_UPDATE, 10'd300, 8'h80);
        write_length(11'd1);
        send_write(MODE_UPDATE, 10'd0,   8'h7F);
        send_write(MODE_UPDATE, 10'd1,   8'h7F);
        send_write(MODE_LOAD,   10'd5,   8'h03);
        send_write(MODE_LOAD,   10'd0,   8'h03);
        send_write(MODE_UPDATE, 10'd0,   8'h7F);
        // excluded characters come back once the length grows again
        write_length(11'd3);
        send_write(MODE_UPDATE, 10'd2,   8'h7F);
        send_write(MODE_UPDATE, 10'd1,   8'h7F);
        write_length(11'd1024);
        send_write(MODE_UPDATE, 10'd1022, 8'h80);
    endtask

    // short strings with two characters, so runs form and break often
    task automatic test_short_strings();
        for (int i = 0; i < 6; i++) begin
            write_length(SLEN_W'($urandom_range(40, 2)));
            gaps_on = (i != 2);
            send_random(50, 2, 10);
        end
        gaps_on = 1'b1;
    endtask

    // full length, small alphabets, one pause until all results are back, then any character
    task automatic test_full_string();
        write_length(11'd1024);
        send_random(150, 3, 0);
        wait_idle();
        gaps_on = 1'b0;
        send_random(100, 2, 0);
        gaps_on = 1'b1;
        send_random(100, 0, 0);
    endtask

    // lengths just below, above and around the maximum, tiny ones too
    task automatic test_odd_lengths();
        write_length(11'd1023);
        send_random(50, 2, 20);
        write_length(SLEN_W'($urandom_range(2047, 1025)));
        send_random(50, 2, 20);
        write_length(SLEN_W'($urandom_range(2047, 0)));
        send_random(50, 0, 30);
        write_length(SLEN_W'($urandom_range(4, 1)));
        send_random(50, 2, 30);
    endtask

    // result check against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (expected_runs.size() == 0) begin
                $error("result with nothing expected: longest_run %0d bad_position %0d",
                       o_result.longest_run, o_result.bad_position);
                error_count++;
            end else begin
                want = expected_runs.pop_front();
                if (o_result.longest_run !== want.longest_run) begin
                    $error("longest_run: expected %0d, got %0d",
                           want.longest_run, o_result.longest_run);
                    error_count++;
                end
                if (o_result.bad_position !== want.bad_position) begin
                    $error("bad_position: expected %0d, got %0d",
                           want.bad_position, o_result.bad_position);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where no transaction of any kind completes
    always @(posedge i_clk) begin
        if ((i_start && o_busy === 1'b0) || o_result_valid === 1'b1 ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL longest_uniform_run_tracker_core");
            $finish;
        end
    end

    // test sequence
    initial begin
        foreach (char_store[p]) begin
            char_store[p] = '0;
        end
        length_reg = 11'd1024;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_string();
        test_length_extremes();
        test_short_strings();
        test_full_string();
        test_odd_lengths();
        wait_idle();
        if (expected_runs.size() != 0) begin
            $error("%0d results never arrived", expected_runs.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS longest_uniform_run_tracker_core");
        end else begin
            $display("FAIL longest_uniform_run_tracker_core");
        end
        $finish;
    end

endmodule

>>> longest_uniform_run_tracker_core.f
hw/rtl/lurt_pkg.sv
hw/rtl/lurt_node_ram.sv
hw/rtl/lurt_merge.sv
hw/rtl/longest_uniform_run_tracker_core.sv
hw/rtl/lurt_checker.sv
test/longest_uniform_run_tracker_core_test.sv
